// File: design/x86bt_pkg.sv
// Shared types and constants of the x86 bus memory/I/O target.
package x86bt_pkg;

  localparam int unsigned MEM_ADDR_BITS = 20;
  localparam int unsigned IO_ADDR_BITS  = 16;
  localparam int unsigned BUS_ADDR_BITS = 20;

  // Each space is split into an even and an odd byte bank.
  localparam int unsigned MEM_ROW_BITS = MEM_ADDR_BITS - 1;
  localparam int unsigned IO_ROW_BITS  = IO_ADDR_BITS - 1;
  localparam int unsigned MEM_ROWS     = 1 << MEM_ROW_BITS;
  localparam int unsigned IO_ROWS      = 1 << IO_ROW_BITS;

  localparam logic [7:0] VEC_TIMER    = 8'h08;
  localparam logic [7:0] VEC_KEYBOARD = 8'h09;

  typedef enum logic [2:0] {
    FN_RD_MEM  = 3'd0,
    FN_WR_MEM  = 3'd1,
    FN_RD_IO   = 3'd2,
    FN_WR_IO   = 3'd3,
    FN_INT_ACK = 3'd4,
    FN_IRQ0    = 3'd5,
    FN_IRQ1    = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    LANE_BOTH = 2'd0,
    LANE_HIGH = 2'd1,
    LANE_LOW  = 2'd2,
    LANE_NONE = 2'd3
  } lane_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_NOIRQ = 2'd2
  } status_e;

  // How the result data is built from the registered bank outputs.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_LOW,
    RD_HIGH,
    RD_WORD,
    RD_VEC
  } rd_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

endpackage

// File: design/x86bt_req_if.sv
// Bus cycle item channel: one processor bus cycle per item.
interface x86bt_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            func;
  logic [x86bt_pkg::BUS_ADDR_BITS-1:0]   address;
  logic [1:0]                            lane_select;
  logic [15:0]                           write_data;

  modport source (output valid, func, address, lane_select, write_data, input ready);
  modport sink   (input valid, func, address, lane_select, write_data, output ready);
endinterface

// File: design/x86bt_rsp_if.sv
// Response item channel: the target's answer to one bus cycle.
interface x86bt_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        drives_bus;
  logic        intr_level;
  logic [1:0]  status;

  modport source (output valid, read_data, drives_bus, intr_level, status, input ready);
  modport sink   (input valid, read_data, drives_bus, intr_level, status, output ready);
endinterface

// File: design/x86_bus_memory_io_target.sv
// Memory, I/O and interrupt target answering 8088/8086 bus cycles.
//
// Each request item is one bus cycle: memory read/write, I/O read/write,
// interrupt acknowledge, or an IRQ0/IRQ1 raise. Main memory and I/O space are
// each held as an even and an odd byte bank (synchronous RAMs with registered
// reads), so a 16-bit word at any byte address - including an odd address
// that wraps past the top of its space - is one access to each bank. An item
// is accepted when req_i.valid and req_i.ready are high; its response
// appears on the next cycle and stays until taken. The target accepts a new
// item in the same cycle that the response is taken, so it sustains one item
// per clock while the sink keeps ready high. The response timing is set by
// the registered bank reads; the one-per-clock rate comes from the single
// response register passing the sink's ready straight back to the request
// side. A write lands in the banks at its accept edge, so a following read
// of the same byte always sees it. Memory contents are undefined after reset
// (no clearing pass); reading a never-written byte returns whatever the RAM
// holds. The wide_bus register (cfg_we_i/cfg_wdata_i) selects the 8-bit bus
// (0) or the 16-bit bus with byte lanes (1); write it only while the target is
// idle. Acknowledge serves IRQ0 first (vector 08h) then IRQ1 (vector 09h).
module x86_bus_memory_io_target (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  x86bt_req_if.sink          req_i,
  x86bt_rsp_if.source        rsp_o
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  x86bt_pkg::state_e state_q, state_d;
  logic wide_bus_q;
  logic timer_q, timer_d;
  logic kbd_q, kbd_d;
  logic intr_line_q, intr_line_d;
  logic accept;

  // Per-item registers feeding the response
  x86bt_pkg::rd_kind_e  kind_q, kind_d;
  x86bt_pkg::status_e   status_q, status_d;
  logic                 io_q;    // response data comes from the I/O banks
  logic                 odd_q;   // first byte lives in the odd bank
  logic                 vec_q;   // 0 timer vector, 1 keyboard vector
  logic                 vec_d;

  // ---------------------------------------------------------------------------
  // Handshake FSM
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;
    case (state_q)
      x86bt_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) state_d = x86bt_pkg::ST_RESP;
      end
      x86bt_pkg::ST_RESP: begin
        rsp_o.valid = 1'b1;
        // next item may enter as the current answer leaves
        req_i.ready = rsp_o.ready;
        if (rsp_o.ready && !req_i.valid) state_d = x86bt_pkg::ST_IDLE;
      end
      default: state_d = x86bt_pkg::ST_IDLE;
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= x86bt_pkg::ST_IDLE;
      wide_bus_q  <= 1'b0;
      timer_q     <= 1'b0;
      kbd_q       <= 1'b0;
      intr_line_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) wide_bus_q <= cfg_wdata_i;
      if (accept) begin
        timer_q     <= timer_d;
        kbd_q       <= kbd_d;
        intr_line_q <= intr_line_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Cycle decode
  // ---------------------------------------------------------------------------
  x86bt_pkg::func_e func;
  x86bt_pkg::lane_e lane;
  logic             lane_ok;
  logic             rd_en, we_a0, we_a1, io_sel;
  logic [7:0]       byte_a0, byte_a1;

  assign func    = x86bt_pkg::func_e'(req_i.func);
  assign lane    = x86bt_pkg::lane_e'(req_i.lane_select);
  assign lane_ok = !wide_bus_q || (lane != x86bt_pkg::LANE_NONE);

  // High-lane-only access moves the addressed byte on lanes 8-15
  assign byte_a0 = (wide_bus_q && lane == x86bt_pkg::LANE_HIGH) ?
                   req_i.write_data[15:8] : req_i.write_data[7:0];
  assign byte_a1 = req_i.write_data[15:8];

  always_comb begin
    timer_d     = timer_q;
    kbd_d       = kbd_q;
    intr_line_d = intr_line_q;
    kind_d      = x86bt_pkg::RD_NONE;
    status_d    = x86bt_pkg::STAT_OK;
    vec_d       = 1'b0;
    rd_en       = 1'b0;
    we_a0       = 1'b0;
    we_a1       = 1'b0;
    io_sel      = 1'b0;
    case (func)
      x86bt_pkg::FN_RD_MEM, x86bt_pkg::FN_RD_IO: begin
        io_sel = (func == x86bt_pkg::FN_RD_IO);
        if (!lane_ok) begin
          status_d = x86bt_pkg::STAT_BAD;
        end else begin
          rd_en = 1'b1;
          if (!wide_bus_q) kind_d = x86bt_pkg::RD_LOW;
          else if (lane == x86bt_pkg::LANE_BOTH) kind_d = x86bt_pkg::RD_WORD;
          else if (lane == x86bt_pkg::LANE_HIGH) kind_d = x86bt_pkg::RD_HIGH;
          else kind_d = x86bt_pkg::RD_LOW;
        end
      end
      x86bt_pkg::FN_WR_MEM, x86bt_pkg::FN_WR_IO: begin
        io_sel = (func == x86bt_pkg::FN_WR_IO);
        if (!lane_ok) begin
          status_d = x86bt_pkg::STAT_BAD;
        end else begin
          we_a0 = 1'b1;
          we_a1 = wide_bus_q && (lane == x86bt_pkg::LANE_BOTH);
        end
      end
      x86bt_pkg::FN_INT_ACK: begin
        if (wide_bus_q && lane != x86bt_pkg::LANE_BOTH) begin
          status_d = x86bt_pkg::STAT_BAD;
        end else if (timer_q) begin
          kind_d      = x86bt_pkg::RD_VEC;
          timer_d     = 1'b0;
          intr_line_d = kbd_q;   // line stays up while IRQ1 still waits
        end else if (kbd_q) begin
          kind_d      = x86bt_pkg::RD_VEC;
          vec_d       = 1'b1;
          kbd_d       = 1'b0;
          intr_line_d = 1'b0;
        end else begin
          status_d = x86bt_pkg::STAT_NOIRQ;
        end
      end
      x86bt_pkg::FN_IRQ0: begin
        timer_d     = 1'b1;
        intr_line_d = 1'b1;
      end
      x86bt_pkg::FN_IRQ1: begin
        kbd_d       = 1'b1;
        intr_line_d = 1'b1;
      end
      default: status_d = x86bt_pkg::STAT_BAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Bank addressing: byte a0 and its neighbor a1 = a0+1 (wrapping)
  // ---------------------------------------------------------------------------
  logic [x86bt_pkg::MEM_ADDR_BITS-1:0] mem_a0;
  logic [x86bt_pkg::MEM_ROW_BITS-1:0]  mem_row, mem_row_inc, mem_even_addr;
  logic [x86bt_pkg::IO_ADDR_BITS-1:0]  io_a0;
  logic [x86bt_pkg::IO_ROW_BITS-1:0]   io_row, io_row_inc, io_even_addr;
  logic                                mem_odd, io_odd;

  assign mem_a0        = req_i.address[x86bt_pkg::MEM_ADDR_BITS-1:0];
  assign mem_odd       = mem_a0[0];
  assign mem_row       = mem_a0[x86bt_pkg::MEM_ADDR_BITS-1:1];
  assign mem_row_inc   = mem_row + 1'b1;
  assign mem_even_addr = mem_odd ? mem_row_inc : mem_row;

  assign io_a0         = req_i.address[x86bt_pkg::IO_ADDR_BITS-1:0];
  assign io_odd        = io_a0[0];
  assign io_row        = io_a0[x86bt_pkg::IO_ADDR_BITS-1:1];
  assign io_row_inc    = io_row + 1'b1;
  assign io_even_addr  = io_odd ? io_row_inc : io_row;

  logic       odd_sel;
  logic       even_we, odd_we;
  logic [7:0] even_wbyte, odd_wbyte;

  assign odd_sel    = io_sel ? io_odd : mem_odd;
  assign even_we    = accept && (odd_sel ? we_a1 : we_a0);
  assign odd_we     = accept && (odd_sel ? we_a0 : we_a1);
  assign even_wbyte = odd_sel ? byte_a1 : byte_a0;
  assign odd_wbyte  = odd_sel ? byte_a0 : byte_a1;

  // ---------------------------------------------------------------------------
  // Byte banks
  // ---------------------------------------------------------------------------
  logic [7:0] mem_even [x86bt_pkg::MEM_ROWS];
  logic [7:0] mem_odd_bank [x86bt_pkg::MEM_ROWS];
  logic [7:0] io_even [x86bt_pkg::IO_ROWS];
  logic [7:0] io_odd_bank [x86bt_pkg::IO_ROWS];
  logic [7:0] mem_even_rd_q, mem_odd_rd_q, io_even_rd_q, io_odd_rd_q;

  always_ff @(posedge clk_i) begin
    if (even_we && !io_sel) mem_even[mem_even_addr] <= even_wbyte;
    if (odd_we && !io_sel)  mem_odd_bank[mem_row]   <= odd_wbyte;
    if (accept && rd_en && !io_sel) begin
      mem_even_rd_q <= mem_even[mem_even_addr];
      mem_odd_rd_q  <= mem_odd_bank[mem_row];
    end
  end

  always_ff @(posedge clk_i) begin
    if (even_we && io_sel) io_even[io_even_addr] <= even_wbyte;
    if (odd_we && io_sel)  io_odd_bank[io_row]   <= odd_wbyte;
    if (accept && rd_en && io_sel) begin
      io_even_rd_q <= io_even[io_even_addr];
      io_odd_rd_q  <= io_odd_bank[io_row];
    end
  end

  // Per-item response info, loaded with the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      io_q     <= io_sel;
      odd_q    <= odd_sel;
      vec_q    <= vec_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Response assembly
  // ---------------------------------------------------------------------------
  logic [7:0] r_even, r_odd, b0, b1;

  assign r_even = io_q ? io_even_rd_q : mem_even_rd_q;
  assign r_odd  = io_q ? io_odd_rd_q  : mem_odd_rd_q;
  assign b0     = odd_q ? r_odd  : r_even;
  assign b1     = odd_q ? r_even : r_odd;

  always_comb begin
    case (kind_q)
      x86bt_pkg::RD_WORD: rsp_o.read_data = {b1, b0};
      x86bt_pkg::RD_HIGH: rsp_o.read_data = {b0, 8'h00};
      x86bt_pkg::RD_LOW:  rsp_o.read_data = {8'h00, b0};
      x86bt_pkg::RD_VEC:  rsp_o.read_data = {8'h00, vec_q ? x86bt_pkg::VEC_KEYBOARD :
                                                             x86bt_pkg::VEC_TIMER};
      default:            rsp_o.read_data = 16'h0000;
    endcase
  end

  assign rsp_o.drives_bus = (kind_q != x86bt_pkg::RD_NONE);
  assign rsp_o.intr_level = intr_line_q;
  assign rsp_o.status     = status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // interrupt line tracks the pending flags
  a_intr_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    intr_line_q == (timer_q || kbd_q))
    else $error("intr line out of step with pending flags");

  // a stalled response blocks new items
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("item accepted while response stalled");

  // every accepted item is answered on the next cycle
  a_accept_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.valid)
    else $error("accepted item produced no response");

  // undriven data reads as zero
  a_undriven_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.drives_bus |-> rsp_o.read_data == 16'h0000)
    else $error("undriven response carries data");

  // an error status never drives the bus
  a_error_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != x86bt_pkg::STAT_OK |-> !rsp_o.drives_bus)
    else $error("error response drives the bus");

endmodule
